FILE: rtl/core/pspfb_pkg.sv
// ----------------------------------------------------------------------------
// pspfb_pkg
// Shared types and constants for the font segment to PFB/PFA writer.
// ----------------------------------------------------------------------------
package pspfb_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] SEG_MARKER = 8'd128;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] END_CODE   = 8'd3;
    localparam logic [6:0] WRAP_LIMIT = 7'd62;
    localparam logic [6:0] HEX_STEP   = 7'd2;

    localparam logic [7:0] SEG_ASCII  = 8'd1;
    localparam logic [7:0] SEG_BINARY = 8'd2;
    localparam logic [7:0] SEG_END    = 8'd5;

    // type codes written into a PFB segment header
    localparam logic [1:0] HDR_ASCII  = 2'd1;
    localparam logic [1:0] HDR_BINARY = 2'd2;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_ASCII  = 2'd1,
        KIND_BINARY = 2'd2,
        KIND_END    = 2'd3
    } kind_t;

    // back-end command codes
    typedef enum logic [1:0] {
        OP_HEAD = 2'd0,   // marker, type, 4 length bytes
        OP_END  = 2'd1,   // marker, 3
        OP_BYTE = 2'd2,   // single byte
        OP_HEX  = 2'd3    // optional newline, two hex digits
    } op_t;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  seg_type;
        logic [31:0] seg_length;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_item_t;

    typedef struct packed {
        op_t         op;
        logic [1:0]  hdr_type;
        logic [31:0] seg_len;
        logic [7:0]  data;
        logic        wrap;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

FILE: rtl/core/pspfb_front.sv
// ----------------------------------------------------------------------------
// pspfb_front
// Accepts input transactions, tracks segment state, emits back-end commands.
// ----------------------------------------------------------------------------
module pspfb_front
    import pspfb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_valid,
    input  logic      cfg_data,
    input  logic      accept,
    input  in_item_t  item,
    output logic      push,
    output cmd_t      cmd
);

    logic       pfb_mode_reg, pfb_mode_next;
    kind_t      prev_kind_reg, prev_kind_next;
    kind_t      cur_kind_reg, cur_kind_next;
    logic [6:0] hex_col_reg, hex_col_next;
    logic       wrap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pfb_mode_reg  <= 1'b0;
            prev_kind_reg <= KIND_ASCII;
            cur_kind_reg  <= KIND_NONE;
            hex_col_reg   <= '0;
        end
        else
        begin
            pfb_mode_reg  <= pfb_mode_next;
            prev_kind_reg <= prev_kind_next;
            cur_kind_reg  <= cur_kind_next;
            hex_col_reg   <= hex_col_next;
        end
    end

    assign wrap = (hex_col_reg > WRAP_LIMIT);

    always_comb
    begin
        pfb_mode_next  = cfg_valid ? cfg_data : pfb_mode_reg;
        prev_kind_next = prev_kind_reg;
        cur_kind_next  = cur_kind_reg;
        hex_col_next   = hex_col_reg;
        push           = 1'b0;
        cmd.op         = OP_BYTE;
        cmd.hdr_type   = HDR_ASCII;
        cmd.seg_len    = item.seg_length - 32'd2;
        cmd.data       = item.data_byte;
        cmd.wrap       = wrap;

        if (accept)
        begin
            if (!item.req_type)
            begin
                unique case (item.seg_type)
                    SEG_ASCII:
                    begin
                        if (pfb_mode_reg)
                        begin
                            push         = 1'b1;
                            cmd.op       = OP_HEAD;
                            cmd.hdr_type = HDR_ASCII;
                        end
                        else if (prev_kind_reg == KIND_BINARY)
                        begin
                            push     = 1'b1;
                            cmd.op   = OP_BYTE;
                            cmd.data = CHAR_LF;
                        end
                        prev_kind_next = KIND_ASCII;
                        cur_kind_next  = KIND_ASCII;
                    end
                    SEG_BINARY:
                    begin
                        if (pfb_mode_reg)
                        begin
                            push         = 1'b1;
                            cmd.op       = OP_HEAD;
                            cmd.hdr_type = HDR_BINARY;
                        end
                        else
                        begin
                            if (prev_kind_reg != KIND_BINARY)
                                hex_col_next = '0;
                            prev_kind_next = KIND_BINARY;
                        end
                        cur_kind_next = KIND_BINARY;
                    end
                    SEG_END:
                    begin
                        if (pfb_mode_reg)
                        begin
                            push   = 1'b1;
                            cmd.op = OP_END;
                        end
                        cur_kind_next = KIND_END;
                    end
                    default:
                        cur_kind_next = KIND_NONE;
                endcase
            end
            else if (cur_kind_reg == KIND_ASCII)
            begin
                push     = 1'b1;
                cmd.op   = OP_BYTE;
                cmd.data = (item.data_byte == CHAR_CR) ? CHAR_LF : item.data_byte;
            end
            else if (cur_kind_reg == KIND_BINARY)
            begin
                push = 1'b1;
                if (pfb_mode_reg)
                    cmd.op = OP_BYTE;
                else
                begin
                    cmd.op       = OP_HEX;
                    hex_col_next = (wrap ? 7'd0 : hex_col_reg) + HEX_STEP;
                end
            end
        end
    end

endmodule

FILE: rtl/core/pspfb_queue.sv
// ----------------------------------------------------------------------------
// pspfb_queue
// Small command queue between front and back end.
// ----------------------------------------------------------------------------
module pspfb_queue
    import pspfb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_t      cmd_in,
    input  logic      pop,
    output cmd_t      cmd_out,
    output q_status_t status
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= cmd_in;
    end

    assign cmd_out      = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

FILE: rtl/core/pspfb_back.sv
// ----------------------------------------------------------------------------
// pspfb_back
// Expands queued commands into output bytes, one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module pspfb_back
    import pspfb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      cmd_in,
    input  q_status_t status,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    logic       busy_reg;
    cmd_t       cmd_reg;
    logic [2:0] step_reg;
    logic       out_valid_reg;
    out_item_t  out_item_reg;

    logic       advance, is_last;
    logic [2:0] last_step, start_step;
    logic [7:0] cur_byte;

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        hex_char = (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
    endfunction

    always_comb
    begin
        case (cmd_reg.op)
            OP_HEAD: last_step = 3'd5;
            OP_END:  last_step = 3'd1;
            OP_HEX:  last_step = 3'd2;
            default: last_step = 3'd0;
        endcase

        case (cmd_reg.op)
            OP_HEAD:
            begin
                case (step_reg)
                    3'd0:    cur_byte = SEG_MARKER;
                    3'd1:    cur_byte = {6'd0, cmd_reg.hdr_type};
                    3'd2:    cur_byte = cmd_reg.seg_len[7:0];
                    3'd3:    cur_byte = cmd_reg.seg_len[15:8];
                    3'd4:    cur_byte = cmd_reg.seg_len[23:16];
                    default: cur_byte = cmd_reg.seg_len[31:24];
                endcase
            end
            OP_END:
                cur_byte = (step_reg == 3'd0) ? SEG_MARKER : END_CODE;
            OP_HEX:
            begin
                case (step_reg)
                    3'd0:    cur_byte = CHAR_LF;
                    3'd1:    cur_byte = hex_char(cmd_reg.data[7:4]);
                    default: cur_byte = hex_char(cmd_reg.data[3:0]);
                endcase
            end
            default:
                cur_byte = cmd_reg.data;
        endcase

        // hex without wrap skips the leading newline
        start_step = (cmd_in.op == OP_HEX && !cmd_in.wrap) ? 3'd1 : 3'd0;
    end

    assign advance = busy_reg && (!out_valid_reg || !out_stall);
    assign is_last = (step_reg == last_step);
    assign pop     = !status.empty && (!busy_reg || (advance && is_last));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
                step_reg <= start_step;
            end
            else if (advance && is_last)
                busy_reg <= 1'b0;
            else if (advance)
                step_reg <= step_reg + 3'd1;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cmd_reg <= cmd_in;
        if (advance)
        begin
            out_item_reg.out_byte    <= cur_byte;
            out_item_reg.last_of_run <= is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

FILE: rtl/core/post_segment_to_pfb_pfa_core.sv
// ----------------------------------------------------------------------------
// post_segment_to_pfb_pfa_core
// Font resource segment stream to PFB or PFA byte stream converter.
// ----------------------------------------------------------------------------
// Input transactions are segment headers (req_type 0) or data bytes
// (req_type 1); each yields zero to six output bytes, the last flagged with
// last_of_run. The front end takes one input transaction per cycle while the
// four-entry command queue has room; the back end drains one output byte per
// cycle while out_stall is low, through a registered output stage. Sustained
// rate is therefore set by output bytes: one per ASCII or PFB binary byte, two
// per PFA hex byte (three on a line wrap), six per PFB segment header and two
// per PFB end header. pfb_mode is written via cfg_valid/cfg_data (always
// ready) and must only change while idle.
// ----------------------------------------------------------------------------
module post_segment_to_pfb_pfa_core
    import pspfb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    // configuration write channel
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data,
    // input transactions
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_item,
    // output transactions
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    logic      in_accept;
    logic      push, pop;
    cmd_t      push_cmd, head_cmd;
    q_status_t q_status;

    // register write never blocks
    assign cfg_ready = 1'b1;

    // front stalls only on a full queue
    assign in_stall  = q_status.full;
    assign in_accept = in_valid && !in_stall;

    pspfb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .accept    (in_accept),
        .item      (in_item),
        .push      (push),
        .cmd       (push_cmd)
    );

    pspfb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (push_cmd),
        .pop     (pop),
        .cmd_out (head_cmd),
        .status  (q_status)
    );

    pspfb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_in    (head_cmd),
        .status    (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // no command pushed into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("command pushed into full queue");

    // no pop from an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("command popped from empty queue");

    // bytes of one run follow without gaps
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !out_item.last_of_run) |=> out_valid)
        else $error("gap inside an output run");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the font segment to PFB/PFA byte writer.
// A clocked driver feeds input transactions from a queue of pending items.
// Each accepted item runs through a behavioral model of the segment writer,
// which queues the output bytes it should produce. A clocked monitor checks
// every output transaction against that queue, field by field. The run covers
// both output modes, directed corner cases, random segment sequences, and
// several sender/receiver idle patterns, including a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import pspfb_pkg::*;

    // Request kinds carried in req_type
    localparam logic REQ_HEADER = 1'b0;
    localparam logic REQ_DATA   = 1'b1;

    // Type codes written into a PFB segment header
    localparam logic [7:0] PFB_ASCII  = 8'd1;
    localparam logic [7:0] PFB_BINARY = 8'd2;

    localparam logic [7:0] ASCII_ZERO = "0";
    localparam logic [7:0] ASCII_A    = "A";

    // The core has a 4-deep command queue plus an output register; an item that
    // yields no bytes pushes no command into the queue.
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_NS     = 10_000_000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data  = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_item_t  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_item;

    // Model state: mirrors the core's view of the mode register and segments
    logic        pfb_on     = 1'b0;
    kind_t       prev_kind  = KIND_ASCII;
    kind_t       cur_kind   = KIND_NONE;
    logic [6:0]  pfa_column = 7'd0;

    in_item_t    pending_items[$];   // filled by the sequencer, drained by the driver
    out_item_t   font_bytes_due[$];  // bytes the model says must come out, in order
    logic [7:0]  run_bytes[$];       // scratch: bytes produced by one input transaction

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_reqs      = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int mismatches     = 0;

    post_segment_to_pfb_pfa_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Behavioral model of the segment writer
    // ------------------------------------------------------------------------
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? ASCII_ZERO + 8'(nib) : ASCII_A + 8'(nib - 4'd10);
    endfunction

    // PFB segment header: marker, type, 32-bit length LSB first
    function automatic void add_pfb_head(input logic [7:0] code, input logic [31:0] len);
        run_bytes.push_back(SEG_MARKER);
        run_bytes.push_back(code);
        run_bytes.push_back(len[7:0]);
        run_bytes.push_back(len[15:8]);
        run_bytes.push_back(len[23:16]);
        run_bytes.push_back(len[31:24]);
    endfunction

    function automatic void predict_font_bytes(input in_item_t it);
        logic [31:0] body_len;
        body_len = it.seg_length - 32'd2;   // length field counts the two type bytes
        run_bytes.delete();
        if (it.req_type == REQ_HEADER)
        begin
            case (it.seg_type)
                SEG_ASCII:
                begin
                    if (pfb_on)
                        add_pfb_head(PFB_ASCII, body_len);
                    else if (prev_kind == KIND_BINARY)
                        run_bytes.push_back(CHAR_LF);
                    prev_kind = KIND_ASCII;
                    cur_kind  = KIND_ASCII;
                end
                SEG_BINARY:
                begin
                    // in PFB mode the header leaves previous kind alone
                    if (pfb_on)
                        add_pfb_head(PFB_BINARY, body_len);
                    else
                    begin
                        if (prev_kind != KIND_BINARY)
                            pfa_column = 7'd0;
                        prev_kind = KIND_BINARY;
                    end
                    cur_kind = KIND_BINARY;
                end
                SEG_END:
                begin
                    if (pfb_on)
                    begin
                        run_bytes.push_back(SEG_MARKER);
                        run_bytes.push_back(END_CODE);
                    end
                    cur_kind = KIND_END;
                end
                default:
                    cur_kind = KIND_NONE;
            endcase
        end
        else if (cur_kind == KIND_ASCII)
        begin
            run_bytes.push_back((it.data_byte == CHAR_CR) ? CHAR_LF : it.data_byte);
        end
        else if (cur_kind == KIND_BINARY)
        begin
            if (pfb_on)
                run_bytes.push_back(it.data_byte);
            else
            begin
                if (pfa_column > WRAP_LIMIT)
                begin
                    run_bytes.push_back(CHAR_LF);
                    pfa_column = 7'd0;
                end
                run_bytes.push_back(hex_char(it.data_byte[7:4]));
                run_bytes.push_back(hex_char(it.data_byte[3:0]));
                pfa_column = pfa_column + HEX_STEP;
            end
        end
        foreach (run_bytes[i])
            font_bytes_due.push_back(out_item_t'{out_byte: run_bytes[i],
                                                 last_of_run: (i == run_bytes.size() - 1)});
    endfunction

    // ------------------------------------------------------------------------
    // Input driver: presents queued items; holds a stalled transaction steady
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                predict_font_bytes(in_item);
            // free to move on when idle or when the current transaction just went in
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_item  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver back-pressure: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_reqs != hold_served)
        begin
            hold_left   = HOLD_CYCLES;
            hold_served = hold_reqs;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Output monitor: every accepted byte must match the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (font_bytes_due.size() == 0)
            begin
                $error("out_byte: nothing expected, got %h (last_of_run %b)",
                       out_item.out_byte, out_item.last_of_run);
                mismatches++;
            end
            else
            begin
                want = font_bytes_due.pop_front();
                if (out_item.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %h, got %h", want.out_byte, out_item.out_byte);
                    mismatches++;
                end
                if (out_item.last_of_run !== want.last_of_run)
                begin
                    $error("last_of_run: expected %b, got %b",
                           want.last_of_run, out_item.last_of_run);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // All fields random, so unused fields toggle too; lengths lean on the wrap edges
    function automatic in_item_t rand_item();
        in_item_t it;
        it.req_type  = 1'($urandom_range(1));
        it.seg_type  = 8'($urandom_range(255));
        it.data_byte = 8'($urandom_range(255));
        case ($urandom_range(7))
            0:       it.seg_length = 32'd0;
            1:       it.seg_length = 32'd1;
            2:       it.seg_length = 32'd2;
            3:       it.seg_length = 32'hFFFF_FFFF;
            default: it.seg_length = $urandom;
        endcase
        return it;
    endfunction

    function automatic in_item_t header_item(input logic [7:0] t, input logic [31:0] len);
        in_item_t it;
        it            = rand_item();
        it.req_type   = REQ_HEADER;
        it.seg_type   = t;
        it.seg_length = len;
        return it;
    endfunction

    function automatic in_item_t data_item(input logic [7:0] b);
        in_item_t it;
        it           = rand_item();
        it.req_type  = REQ_DATA;
        it.data_byte = b;
        return it;
    endfunction

    // Mostly well-formed segments (header then bytes), with some stray items.
    // Bytes that the core drops are not counted toward the target.
    task automatic queue_segment_runs(input int target);
        int         counted;
        int         pick;
        int         nbytes;
        logic [7:0] seg;
        logic [7:0] b;
        in_item_t   hdr;
        counted = 0;
        while (counted < target)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                pending_items.push_back(rand_item());
                counted++;
            end
            else
            begin
                if (pick < 35)
                begin
                    seg    = SEG_ASCII;
                    nbytes = $urandom_range(8);
                end
                else if (pick < 75)
                begin
                    seg    = SEG_BINARY;
                    // now and then a long run to cross the hex line wrap
                    nbytes = ($urandom_range(5) == 0) ? $urandom_range(45, 30)
                                                      : $urandom_range(10);
                end
                else if (pick < 85)
                begin
                    seg    = SEG_END;
                    nbytes = $urandom_range(3);
                end
                else
                begin
                    do
                        seg = 8'($urandom_range(255));
                    while (seg == SEG_ASCII || seg == SEG_BINARY || seg == SEG_END);
                    nbytes = $urandom_range(3);
                end
                hdr = rand_item();
                hdr.req_type = REQ_HEADER;
                hdr.seg_type = seg;
                pending_items.push_back(hdr);
                counted++;
                repeat (nbytes)
                begin
                    b = 8'($urandom_range(255));
                    if (seg == SEG_ASCII && $urandom_range(4) == 0)
                        b = CHAR_CR;
                    pending_items.push_back(data_item(b));
                    if (seg == SEG_ASCII || seg == SEG_BINARY)
                        counted++;
                end
            end
        end
    endtask

    // Wait until every queued transaction is in and every byte is out, then
    // let the core settle.
    task automatic drain();
        while (pending_items.size() != 0 || in_valid || font_bytes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write; call with the core idle
    task automatic write_mode(input logic mode);
        cfg_data  <= mode;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        pfb_on = mode;
    endtask

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // PFA mode straight out of reset
        pending_items.push_back(data_item(8'h41));                 // no segment yet: dropped
        pending_items.push_back(header_item(SEG_ASCII, 32'd2));     // after ascii: no newline
        pending_items.push_back(data_item(CHAR_CR));                // CR becomes LF
        pending_items.push_back(data_item(8'h00));
        pending_items.push_back(data_item(8'hFF));
        pending_items.push_back(header_item(SEG_BINARY, 32'hFFFF_FFFF)); // column restarts
        pending_items.push_back(data_item(8'h00));
        pending_items.push_back(data_item(8'hFF));
        pending_items.push_back(data_item(8'h5A));
        pending_items.push_back(header_item(SEG_ASCII, 32'd0));     // newline after hex
        pending_items.push_back(header_item(SEG_END, 32'd5));       // silent in PFA
        pending_items.push_back(data_item(8'h33));                  // end segment data dropped
        pending_items.push_back(header_item(8'h00, 32'd7));         // unknown type
        pending_items.push_back(data_item(8'h77));
        pending_items.push_back(header_item(8'hFF, 32'd9));
        drain();

        // PFB mode: headers with wrapped lengths, raw binary, end header
        write_mode(1'b1);
        pending_items.push_back(header_item(SEG_ASCII, 32'd0));
        pending_items.push_back(data_item(CHAR_CR));
        pending_items.push_back(header_item(SEG_BINARY, 32'd1));
        pending_items.push_back(data_item(8'h00));
        pending_items.push_back(data_item(8'hFF));
        pending_items.push_back(data_item(CHAR_CR));                // raw in binary
        pending_items.push_back(header_item(SEG_BINARY, 32'hFFFF_FFFF));
        pending_items.push_back(header_item(SEG_END, 32'd0));
        pending_items.push_back(data_item(8'hC3));
        pending_items.push_back(header_item(END_CODE, 32'd4));      // 3 is not a type here
        drain();

        // Random phases; mode flips between them, sometimes mid-segment
        write_mode(1'b0);
        queue_segment_runs(50);
        drain();

        write_mode(1'b1);
        send_idle_pct = 71;
        queue_segment_runs(50);
        drain();

        write_mode(1'b0);
        send_idle_pct  = 0;
        recv_stall_pct = 71;
        queue_segment_runs(45);
        drain();

        write_mode(1'b1);
        send_idle_pct  = 8;
        recv_stall_pct = 8;
        queue_segment_runs(40);
        drain();

        // Long receiver hold-off while the sender keeps pushing: core must fill
        // and stall its input without losing or reordering anything.
        write_mode(1'b0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_segment_runs(25);
        hold_reqs++;
        drain();

        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        #LIMIT_NS;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
